### design/utad_pkg.sv
// Shared types, constants and helpers for the unsigned-to-ASCII digit converter.
// No dependencies.
package utad_pkg;

  localparam int MAX_LENGTH_DEF = 32;
  localparam int DIGIT_W        = 4;
  localparam int FIELD_LEN_W    = 6;
  localparam int VALUE_W        = 64;
  localparam int DEC_W          = 32;
  localparam int CHAR_W         = 8;

  // n / 10 == (n * DEC_RECIP) >> DEC_SHIFT for every 32-bit n
  localparam logic [DEC_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int               DEC_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
  localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;

  typedef struct packed {
    logic [VALUE_W-1:0]     value;
    logic                   radix_hex;
    logic                   uppercase;
    logic [FIELD_LEN_W-1:0] field_length;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic hex;
  } du_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FETCH,
    ST_SHOW
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER : CHAR_LOWER;
    if (d < DEC_BASE) begin
      digit_to_ascii = CHAR_ZERO + CHAR_W'(d);
    end else begin
      digit_to_ascii = base + CHAR_W'(d - DEC_BASE);
    end
  endfunction

endpackage

### design/unsigned_to_ascii_digits.sv
// Top level: unsigned value to fixed-length ASCII digit string, MSB first.
// Uses utad_pkg, utad_digit_unit and utad_ram.
// A new item is taken only in idle, once the last character of the previous one is accepted;
// a zero-length item produces no characters. One digit per cycle from the shared digit unit,
// then one character per cycle read back from the digit RAM while out_ready is high.
// Reset (rst_n, synchronous): sequencer returns to idle; digit RAM is not cleared.
module unsigned_to_ascii_digits
  import utad_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W = $clog2(MAX_LENGTH);

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               upper_r, upper_nxt;
  logic [LEN_W-1:0]   len_in;
  logic               in_fire, out_fire, is_last;
  du_ctl_t            du_ctl;
  logic [DIGIT_W-1:0] digit, rd_digit;
  logic               ram_we, ram_re;

  assign len_in = (int'(in_data.field_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH)
                                                            : LEN_W'(in_data.field_length);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign is_last  = (rd_idx_r == len_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (len_in != '0)) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_SHOW;
      ST_SHOW: begin
        if (out_fire && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    du_ctl.load = 1'b0;
    du_ctl.step = 1'b0;
    du_ctl.hex  = in_data.radix_hex;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        du_ctl.load = in_fire;
      end
      ST_CONV: begin
        du_ctl.step = 1'b1;
        ram_we      = 1'b1;
      end
      ST_FETCH: ram_re = 1'b1;
      ST_SHOW: begin
        out_valid = 1'b1;
        ram_re    = out_fire && !is_last;
      end
      default: ;
    endcase
  end

  always_comb begin
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    upper_nxt  = upper_r;
    if (in_fire) begin
      len_nxt   = len_in;
      cnt_nxt   = len_in;
      upper_nxt = in_data.radix_hex && in_data.uppercase;
    end
    if (ram_we) begin
      cnt_nxt    = cnt_r - 1'b1;
      rd_idx_nxt = '0;
    end
    if (state_r == ST_SHOW && ram_re) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    upper_r <= upper_nxt;
  end

  utad_digit_unit u_digit (
    .clk   (clk),
    .ctl   (du_ctl),
    .value (in_data.value),
    .digit (digit)
  );

  utad_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_LENGTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(cnt_r - 1'b1)),
    .wdata (digit),
    .re    (ram_re),
    .raddr (ADDR_W'(rd_idx_nxt)),
    .rdata (rd_digit)
  );

  assign out_data.character = digit_to_ascii(rd_digit, upper_r);
  assign out_data.last      = is_last;

endmodule

### design/utad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utad_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/utad_digit_unit.sv
// Shared digit extractor: holds the remaining value and peels one digit per step
// (reciprocal multiply by 1/10, or a 4-bit shift in hex). Uses utad_pkg.
module utad_digit_unit
  import utad_pkg::*;
(
  input  logic               clk,
  input  du_ctl_t            ctl,
  input  logic [VALUE_W-1:0] value,
  output logic [DIGIT_W-1:0] digit
);

  logic [VALUE_W-1:0]   rem_r, rem_nxt;
  logic                 hex_r;
  logic [DEC_W-1:0]     x;
  logic [2*DEC_W-1:0]   prod;
  logic [DEC_W-DEC_SHIFT+DEC_W-1:0] q;
  logic [DEC_W-1:0]     q10;
  logic [DIGIT_W-1:0]   dec_digit;

  assign x    = rem_r[DEC_W-1:0];
  assign prod = {{DEC_W{1'b0}}, x} * {{DEC_W{1'b0}}, DEC_RECIP};
  assign q    = prod[2*DEC_W-1:DEC_SHIFT];
  assign q10  = DEC_W'({q, 3'b000}) + DEC_W'({q, 1'b0});
  assign dec_digit = DIGIT_W'(x - q10);
  assign digit     = hex_r ? rem_r[DIGIT_W-1:0] : dec_digit;

  always_comb begin
    rem_nxt = rem_r;
    if (ctl.load) begin
      rem_nxt = ctl.hex ? value : {{(VALUE_W-DEC_W){1'b0}}, value[DEC_W-1:0]};
    end else if (ctl.step) begin
      rem_nxt = hex_r ? (rem_r >> DIGIT_W) : VALUE_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (ctl.load) begin
      hex_r <= ctl.hex;
    end
  end

endmodule

### sim/tb_unsigned_to_ascii_digits.sv
`timescale 1ns / 1ps
// Self-checking testbench for unsigned_to_ascii_digits: directed and random conversions,
// predicted per character by a scoreboard class. Depends on utad_pkg and the design files.
module tb_unsigned_to_ascii_digits;
  import utad_pkg::*;

  localparam int MAX_LEN    = MAX_LENGTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_OFF   = 400;

  class ascii_digit_board;
    out_t expected_chars[$];
    int   conversions;
    int   chars_checked;
    int   errors;

    function new();
      conversions   = 0;
      chars_checked = 0;
      errors        = 0;
    endfunction

    function void note_conversion(in_t item);
      logic [VALUE_W-1:0] rem;
      logic [VALUE_W-1:0] base;
      logic [3:0]         digits[MAX_LEN];
      int                 len;
      bit                 upper;
      out_t               ch;
      len   = (item.field_length > MAX_LEN) ? MAX_LEN : int'(item.field_length);
      base  = item.radix_hex ? 64'd16 : 64'd10;
      rem   = item.radix_hex ? item.value : {32'd0, item.value[31:0]};
      upper = item.radix_hex && item.uppercase;
      for (int i = len; i > 0; i--) begin
        digits[i-1] = 4'(rem % base);
        rem = rem / base;
      end
      for (int i = 0; i < len; i++) begin
        if (digits[i] < 4'd10) begin
          ch.character = CHAR_ZERO + 8'(digits[i]);
        end else begin
          ch.character = (upper ? CHAR_UPPER : CHAR_LOWER) + 8'(digits[i]) - 8'd10;
        end
        ch.last = (i + 1 == len);
        expected_chars.push_back(ch);
      end
      conversions++;
    endfunction

    function void check_character(out_t got);
      out_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character 0x%02h last=%0b", got.character, got.last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.character !== want.character) begin
        $error("character: expected 0x%02h, actual 0x%02h", want.character, got.character);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  bit hold_off_req   = 1'b0;
  int idle_cycles    = 0;

  ascii_digit_board board;

  unsigned_to_ascii_digits #(.MAX_LENGTH(MAX_LEN)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_t make_conversion(logic [63:0] value, bit hex, bit upper,
                                          logic [5:0] len);
    in_t item;
    item.value        = value;
    item.radix_hex    = hex;
    item.uppercase    = upper;
    item.field_length = len;
    return item;
  endfunction

  function automatic in_t random_conversion();
    logic [63:0] value;
    logic [5:0]  len;
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      2:       value = 64'($urandom_range(0, 99));
      3:       value = 64'd1 << $urandom_range(0, 63);
      default: value = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 19))
      0:       len = 6'd0;
      1:       len = 6'($urandom_range(33, 63));
      2:       len = 6'd32;
      3, 4, 5, 6, 7, 8, 9:
               len = 6'($urandom_range(1, 32));
      default: len = 6'($urandom_range(1, 12));
    endcase
    return make_conversion(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len);
  endfunction

  task automatic send_conversion(in_t item);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_character(out_data);
      if (in_valid && in_ready) board.note_conversion(in_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("no transaction for %0d cycles", IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    send_conversion(make_conversion(64'd0, 1'b0, 1'b0, 6'd1));
    send_conversion(make_conversion(64'd0, 1'b1, 1'b1, 6'd32));
    send_conversion(make_conversion(64'd9, 1'b0, 1'b0, 6'd1));
    send_conversion(make_conversion(64'd10, 1'b0, 1'b1, 6'd2));
    send_conversion(make_conversion(64'hFFFF_FFFF, 1'b0, 1'b0, 6'd10));
    send_conversion(make_conversion(64'hFFFF_FFFF, 1'b0, 1'b0, 6'd32));
    send_conversion(make_conversion('1, 1'b0, 1'b1, 6'd12));
    send_conversion(make_conversion(64'hDEAD_BEEF_0000_0007, 1'b0, 1'b0, 6'd3));
    send_conversion(make_conversion(64'd1234567890, 1'b0, 1'b0, 6'd4));
    send_conversion(make_conversion('1, 1'b1, 1'b1, 6'd16));
    send_conversion(make_conversion('1, 1'b1, 1'b0, 6'd16));
    send_conversion(make_conversion('1, 1'b1, 1'b0, 6'd32));
    send_conversion(make_conversion(64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 6'd16));
    send_conversion(make_conversion(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 6'd16));
    send_conversion(make_conversion(64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 6'd5));
    send_conversion(make_conversion(64'hF, 1'b1, 1'b1, 6'd1));
    send_conversion(make_conversion(64'hA, 1'b1, 1'b0, 6'd1));
    send_conversion(make_conversion(64'd42, 1'b0, 1'b0, 6'd0));
    send_conversion(make_conversion('1, 1'b1, 1'b1, 6'd0));
    send_conversion(make_conversion(64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 6'd33));
    send_conversion(make_conversion(64'hFFFF_FFFF, 1'b0, 1'b0, 6'd63));
    send_conversion(make_conversion(64'd7, 1'b0, 1'b0, 6'd8));

    for (int i = 0; i < 330; i++) send_conversion(random_conversion());

    // long receiver hold-off with the sender pushing back to back
    sender_idles = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 30; i++) send_conversion(random_conversion());
    while (hold_off_req) @(posedge clk);

    receiver_idles = 1'b0;
    for (int i = 0; i < 40; i++) send_conversion(random_conversion());
    in_valid <= 1'b0;

    while (board.expected_chars.size() != 0) @(posedge clk);
    repeat (2 * MAX_LEN + 8) @(posedge clk);

    $display("%0d conversions, %0d characters checked: decimal and hex, both cases,",
             board.conversions, board.chars_checked);
    $display("zero, saturated and truncated lengths, random stalls and a long output hold-off");
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
